// File: design/tbt_pkg.sv
package tbt_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS   = 16;
	localparam int CORNERS     = 3;

	typedef struct packed {
		logic                          face_start;
		logic signed [COORD_WIDTH-1:0] pos_x;
		logic signed [COORD_WIDTH-1:0] pos_y;
		logic signed [COORD_WIDTH-1:0] pos_z;
		logic signed [COORD_WIDTH-1:0] tex_u;
		logic signed [COORD_WIDTH-1:0] tex_v;
	} corner_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] tangent_x;
		logic signed [COORD_WIDTH-1:0] tangent_y;
		logic signed [COORD_WIDTH-1:0] tangent_z;
		logic signed [COORD_WIDTH-1:0] bitangent_x;
		logic signed [COORD_WIDTH-1:0] bitangent_y;
		logic signed [COORD_WIDTH-1:0] bitangent_z;
		logic                          degenerate;
	} result_t;

	typedef enum logic [2:0] {
		MS_DU1_DV2,
		MS_DU2_DV1,
		MS_DV2_E1,
		MS_DV1_E2,
		MS_DU1_E2,
		MS_DU2_E1
	} mul_sel_t;

	typedef struct packed {
		logic     ld_c0;
		logic     ld_c1;
		logic     ld_delta;
		logic     mul_ld;
		mul_sel_t sel;
		logic [1:0] comp;
		logic     acc_ld;
		logic     acc_sub;
		logic     det_ld;
		logic     res_clear;
		logic     div_start;
		logic     div_step;
		logic     res_ld;
		logic [2:0] res_idx;
		logic     out_ld;
	} cmd_t;

	typedef struct packed {
		logic face_start;
		logic det_zero;
		logic div_last;
		logic out_free;
	} sts_t;

endpackage

// File: design/tbt_ctrl.sv
module tbt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          corner_valid,
	output logic          corner_stall,
	input  tbt_pkg::sts_t sts,
	output tbt_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL_A,
		S_MUL_B,
		S_SUB,
		S_DET,
		S_DIV_INIT,
		S_DIV,
		S_DIV_END,
		S_FINISH
	} state_t;

	localparam logic [2:0] JOB_DET  = 3'd0;
	localparam logic [2:0] JOB_BIT0 = 3'd4;
	localparam logic [2:0] JOB_LAST = 3'd6;

	state_t     state_q;
	logic [1:0] cnt_q;
	logic [2:0] job_q;
	logic [1:0] cnt_now;
	logic       accept;

	assign corner_stall = (state_q != S_IDLE);
	assign accept       = corner_valid && (state_q == S_IDLE);
	assign cnt_now      = sts.face_start ? 2'd0 : cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= 2'd0;
			job_q   <= JOB_DET;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (cnt_now == 2'(tbt_pkg::CORNERS - 1)) begin
							cnt_q   <= 2'd0;
							job_q   <= JOB_DET;
							state_q <= S_MUL_A;
						end else begin
							cnt_q <= cnt_now + 2'd1;
						end
					end
				end
				S_MUL_A: state_q <= S_MUL_B;
				S_MUL_B: state_q <= S_SUB;
				S_SUB: begin
					state_q <= (job_q == JOB_DET) ? S_DET : S_DIV_INIT;
				end
				S_DET: begin
					if (sts.det_zero) begin
						state_q <= S_FINISH;
					end else begin
						job_q   <= job_q + 3'd1;
						state_q <= S_MUL_A;
					end
				end
				S_DIV_INIT: state_q <= S_DIV;
				S_DIV: begin
					if (sts.div_last) state_q <= S_DIV_END;
				end
				S_DIV_END: begin
					if (job_q == JOB_LAST) begin
						state_q <= S_FINISH;
					end else begin
						job_q   <= job_q + 3'd1;
						state_q <= S_MUL_A;
					end
				end
				S_FINISH: begin
					if (sts.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd         = '0;
		cmd.sel     = tbt_pkg::MS_DU1_DV2;
		cmd.comp    = (job_q >= JOB_BIT0) ? 2'(job_q - JOB_BIT0) : 2'(job_q - 3'd1);
		cmd.res_idx = job_q - 3'd1;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (cnt_now)
						2'd0:    cmd.ld_c0    = 1'b1;
						2'd1:    cmd.ld_c1    = 1'b1;
						default: cmd.ld_delta = 1'b1;
					endcase
				end
			end
			S_MUL_A: begin
				cmd.mul_ld = 1'b1;
				if (job_q == JOB_DET)       cmd.sel = tbt_pkg::MS_DU1_DV2;
				else if (job_q < JOB_BIT0)  cmd.sel = tbt_pkg::MS_DV2_E1;
				else                        cmd.sel = tbt_pkg::MS_DU1_E2;
			end
			S_MUL_B: begin
				cmd.mul_ld = 1'b1;
				cmd.acc_ld = 1'b1;
				if (job_q == JOB_DET)       cmd.sel = tbt_pkg::MS_DU2_DV1;
				else if (job_q < JOB_BIT0)  cmd.sel = tbt_pkg::MS_DV1_E2;
				else                        cmd.sel = tbt_pkg::MS_DU2_E1;
			end
			S_SUB:      cmd.acc_sub = 1'b1;
			S_DET: begin
				cmd.res_clear = sts.det_zero;
				cmd.det_ld    = !sts.det_zero;
			end
			S_DIV_INIT: cmd.div_start = 1'b1;
			S_DIV:      cmd.div_step  = 1'b1;
			S_DIV_END:  cmd.res_ld    = 1'b1;
			S_FINISH:   cmd.out_ld    = sts.out_free;
			default:    cmd.out_ld    = 1'b0;
		endcase
	end

endmodule

// File: design/tbt_datapath.sv
module tbt_datapath #(
	parameter int FRAC_BITS = tbt_pkg::FRAC_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tbt_pkg::corner_t corner,
	input  logic             result_stall,
	output logic             result_valid,
	output tbt_pkg::result_t result,
	input  tbt_pkg::cmd_t    cmd,
	output tbt_pkg::sts_t    sts
);

	localparam int CW   = tbt_pkg::COORD_WIDTH;
	localparam int DW   = CW + 1;
	localparam int PW   = 2 * DW;
	localparam int XW   = PW + 1;
	localparam int NW   = XW + FRAC_BITS;
	localparam int CNTW = $clog2(NW + 1);

	logic signed [CW-1:0] pos_in [3];
	logic signed [CW-1:0] c0_pos_q [3];
	logic signed [CW-1:0] c1_pos_q [3];
	logic signed [CW-1:0] c0_u_q, c0_v_q, c1_u_q, c1_v_q;
	logic signed [DW-1:0] e1_q [3];
	logic signed [DW-1:0] e2_q [3];
	logic signed [DW-1:0] du1_q, dv1_q, du2_q, dv2_q;
	logic signed [DW-1:0] e1_pick, e2_pick, op_a, op_b;
	logic signed [PW-1:0] prod_q;
	logic signed [XW-1:0] acc_q;
	logic [XW-1:0]        amag, dmag_q;
	logic                 det_neg_q;
	logic [NW-1:0]        n_q, q_q, qneg;
	logic [XW:0]          r_q, r2;
	logic                 ge, neg_q;
	logic [CNTW-1:0]      cnt_q;
	logic                 big_pos, big_neg;
	logic [CW-1:0]        sat;
	logic [CW-1:0]        res_q [6];
	logic                 deg_q;
	logic                 valid_q;

	assign pos_in[0] = corner.pos_x;
	assign pos_in[1] = corner.pos_y;
	assign pos_in[2] = corner.pos_z;

	always_comb begin
		case (cmd.comp)
			2'd0:    begin e1_pick = e1_q[0]; e2_pick = e2_q[0]; end
			2'd1:    begin e1_pick = e1_q[1]; e2_pick = e2_q[1]; end
			default: begin e1_pick = e1_q[2]; e2_pick = e2_q[2]; end
		endcase
		case (cmd.sel)
			tbt_pkg::MS_DU1_DV2: begin op_a = du1_q; op_b = dv2_q;   end
			tbt_pkg::MS_DU2_DV1: begin op_a = du2_q; op_b = dv1_q;   end
			tbt_pkg::MS_DV2_E1:  begin op_a = dv2_q; op_b = e1_pick; end
			tbt_pkg::MS_DV1_E2:  begin op_a = dv1_q; op_b = e2_pick; end
			tbt_pkg::MS_DU1_E2:  begin op_a = du1_q; op_b = e2_pick; end
			tbt_pkg::MS_DU2_E1:  begin op_a = du2_q; op_b = e1_pick; end
			default:             begin op_a = '0;    op_b = '0;      end
		endcase
	end

	assign amag = acc_q[XW-1] ? XW'(-acc_q) : XW'(acc_q);
	assign r2   = {r_q[XW-1:0], n_q[NW-1]};
	assign ge   = (r2 >= {1'b0, dmag_q});
	assign qneg = NW'(0) - q_q;

	assign big_neg = (q_q > (NW'(1) << (CW - 1)));
	assign big_pos = (q_q > ((NW'(1) << (CW - 1)) - NW'(1)));
	always_comb begin
		if (neg_q) sat = big_neg ? {1'b1, {(CW-1){1'b0}}} : qneg[CW-1:0];
		else       sat = big_pos ? {1'b0, {(CW-1){1'b1}}} : q_q[CW-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_c0) begin
			for (int i = 0; i < 3; i++) c0_pos_q[i] <= pos_in[i];
			c0_u_q <= corner.tex_u;
			c0_v_q <= corner.tex_v;
		end
		if (cmd.ld_c1) begin
			for (int i = 0; i < 3; i++) c1_pos_q[i] <= pos_in[i];
			c1_u_q <= corner.tex_u;
			c1_v_q <= corner.tex_v;
		end
		if (cmd.ld_delta) begin
			for (int i = 0; i < 3; i++) begin
				e1_q[i] <= DW'(c1_pos_q[i]) - DW'(c0_pos_q[i]);
				e2_q[i] <= DW'(pos_in[i]) - DW'(c0_pos_q[i]);
			end
			du1_q <= DW'(c1_u_q) - DW'(c0_u_q);
			dv1_q <= DW'(c1_v_q) - DW'(c0_v_q);
			du2_q <= DW'(corner.tex_u) - DW'(c0_u_q);
			dv2_q <= DW'(corner.tex_v) - DW'(c0_v_q);
		end
		if (cmd.mul_ld)  prod_q <= op_a * op_b;
		if (cmd.acc_ld)  acc_q  <= XW'(prod_q);
		if (cmd.acc_sub) acc_q  <= acc_q - XW'(prod_q);
		if (cmd.det_ld) begin
			dmag_q    <= amag;
			det_neg_q <= acc_q[XW-1];
			deg_q     <= 1'b0;
		end
		if (cmd.div_start) begin
			n_q   <= NW'(amag) << FRAC_BITS;
			neg_q <= acc_q[XW-1] ^ det_neg_q;
			r_q   <= '0;
			q_q   <= '0;
			cnt_q <= CNTW'(NW);
		end
		if (cmd.div_step) begin
			r_q   <= ge ? (r2 - {1'b0, dmag_q}) : r2;
			q_q   <= {q_q[NW-2:0], ge};
			n_q   <= n_q << 1;
			cnt_q <= cnt_q - CNTW'(1);
		end
		if (cmd.res_clear) begin
			for (int i = 0; i < 6; i++) res_q[i] <= '0;
			deg_q <= 1'b1;
		end
		if (cmd.res_ld) res_q[cmd.res_idx] <= sat;
		if (cmd.out_ld) begin
			result.tangent_x   <= res_q[0];
			result.tangent_y   <= res_q[1];
			result.tangent_z   <= res_q[2];
			result.bitangent_x <= res_q[3];
			result.bitangent_y <= res_q[4];
			result.bitangent_z <= res_q[5];
			result.degenerate  <= deg_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			if (cmd.out_ld)         valid_q <= 1'b1;
			else if (!result_stall) valid_q <= 1'b0;
		end
	end

	assign result_valid   = valid_q;
	assign sts.face_start = corner.face_start;
	assign sts.det_zero   = (acc_q == '0);
	assign sts.div_last   = (cnt_q == CNTW'(1));
	assign sts.out_free   = !valid_q || !result_stall;

endmodule

// File: design/triangle_tangent_bitangent_top.sv
// channel   direction   handshake                     payload
// corner    in          corner_valid / corner_stall   tbt_pkg::corner_t
// result    out         result_valid / result_stall   tbt_pkg::result_t
//
// first and second corners are stored in corner registers as they are taken
// third corner: the determinant is formed first, then per component two multiplies and
// a subtract feed a restoring divider of 2*COORD_WIDTH+3+FRAC_BITS steps, six times;
// the run time is set by the one-bit-per-cycle divider
// reset clears the corner count and the result valid; the result register holds
// while stalled, and new corners are taken while it waits
module triangle_tangent_bitangent_top #(
	parameter int FRAC_BITS = tbt_pkg::FRAC_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             corner_valid,
	output logic             corner_stall,
	input  tbt_pkg::corner_t corner,
	output logic             result_valid,
	input  logic             result_stall,
	output tbt_pkg::result_t result
);

	tbt_pkg::cmd_t cmd;
	tbt_pkg::sts_t sts;

	tbt_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.corner_valid (corner_valid),
		.corner_stall (corner_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	tbt_datapath #(
		.FRAC_BITS (FRAC_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.corner       (corner),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result       (result),
		.cmd          (cmd),
		.sts          (sts)
	);

endmodule

// File: design/tbt_checker.sv
module tbt_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             corner_valid,
	input logic             corner_stall,
	input tbt_pkg::corner_t corner,
	input logic             result_valid,
	input logic             result_stall,
	input tbt_pkg::result_t result
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result dropped or changed");

	a_rise_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(corner_stall))
		else $error("result appeared without a computation");

	a_first_corner: assert property (@(posedge clk) disable iff (!arst_n)
		corner_valid && !corner_stall && corner.face_start |=> !corner_stall)
		else $error("first corner of a face started a computation");

	a_degenerate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.degenerate |->
			result.tangent_x == '0 && result.tangent_y == '0 &&
			result.tangent_z == '0 && result.bitangent_x == '0 &&
			result.bitangent_y == '0 && result.bitangent_z == '0)
		else $error("degenerate result with nonzero vectors");

endmodule

bind triangle_tangent_bitangent_top tbt_checker u_tbt_checker (.*);

// File: dv/tb_triangle_tangent_bitangent_top.sv
`timescale 1ns / 1ps

module tb_triangle_tangent_bitangent_top;
	import tbt_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_CORNERS = 750;
	localparam int HOLD_START = 20000;
	localparam int HOLD_CYCLES = 3000;
	localparam logic signed [31:0] ONE = 32'sh0001_0000;
	localparam logic signed [31:0] MAXV = 32'sh7fff_ffff;
	localparam logic signed [31:0] MINV = 32'sh8000_0000;

	typedef struct {
		corner_t c;
		bit      typed;
		result_t r;
	} row_t;

	logic    clk;
	logic    arst_n;
	logic    corner_valid;
	logic    corner_stall;
	corner_t corner;
	logic    result_valid;
	logic    result_stall;
	result_t result;

	result_t tangent_q[$];
	row_t    plan[$];
	int      errors;
	int      cycles;
	bit      calm;

	// predictor state
	logic [1:0]        corner_cnt;
	logic signed [31:0] c0_pos[3];
	logic signed [31:0] c0_uv[2];
	logic signed [31:0] c1_pos[3];
	logic signed [31:0] c1_uv[2];

	triangle_tangent_bitangent_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.corner_valid(corner_valid),
		.corner_stall(corner_stall),
		.corner(corner),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic signed [31:0] fixed_div(logic signed [127:0] num,
			logic signed [127:0] den);
		logic [127:0] n;
		logic [127:0] d;
		logic [127:0] q;
		bit           neg;
		neg = num[127] ^ den[127];
		n = num[127] ? -num : num;
		d = den[127] ? -den : den;
		n = n << FRAC_BITS;
		q = n / d;
		if (neg) begin
			if (q > 128'h8000_0000)
				return MINV;
			return -q[31:0];
		end
		if (q > 128'h7fff_ffff)
			return MAXV;
		return q[31:0];
	endfunction

	function automatic bit tangent_step(corner_t c, output result_t r);
		logic signed [127:0] e1[3];
		logic signed [127:0] e2[3];
		logic signed [127:0] du1, dv1, du2, dv2, det;
		logic signed [31:0]  p[3];
		p[0] = c.pos_x;
		p[1] = c.pos_y;
		p[2] = c.pos_z;
		r = '0;
		if (c.face_start || corner_cnt >= 2'd3)
			corner_cnt = 2'd0;
		if (corner_cnt == 2'd0) begin
			c0_pos = p;
			c0_uv[0] = c.tex_u;
			c0_uv[1] = c.tex_v;
			corner_cnt = 2'd1;
			return 1'b0;
		end
		if (corner_cnt == 2'd1) begin
			c1_pos = p;
			c1_uv[0] = c.tex_u;
			c1_uv[1] = c.tex_v;
			corner_cnt = 2'd2;
			return 1'b0;
		end
		corner_cnt = 2'd0;
		for (int i = 0; i < 3; i++) begin
			e1[i] = 128'(c1_pos[i]) - 128'(c0_pos[i]);
			e2[i] = 128'(p[i]) - 128'(c0_pos[i]);
		end
		du1 = 128'(c1_uv[0]) - 128'(c0_uv[0]);
		dv1 = 128'(c1_uv[1]) - 128'(c0_uv[1]);
		du2 = 128'(c.tex_u) - 128'(c0_uv[0]);
		dv2 = 128'(c.tex_v) - 128'(c0_uv[1]);
		det = du1 * dv2 - du2 * dv1;
		if (det == 0) begin
			r.degenerate = 1'b1;
			return 1'b1;
		end
		r.tangent_x = fixed_div(dv2 * e1[0] - dv1 * e2[0], det);
		r.tangent_y = fixed_div(dv2 * e1[1] - dv1 * e2[1], det);
		r.tangent_z = fixed_div(dv2 * e1[2] - dv1 * e2[2], det);
		r.bitangent_x = fixed_div(du1 * e2[0] - du2 * e1[0], det);
		r.bitangent_y = fixed_div(du1 * e2[1] - du2 * e1[1], det);
		r.bitangent_z = fixed_div(du1 * e2[2] - du2 * e1[2], det);
		return 1'b1;
	endfunction

	function automatic corner_t mk(bit fs, logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic [31:0] u, logic [31:0] v);
		corner_t c;
		c.face_start = fs;
		c.pos_x = x;
		c.pos_y = y;
		c.pos_z = z;
		c.tex_u = u;
		c.tex_v = v;
		return c;
	endfunction

	function automatic void add(corner_t c);
		row_t row;
		row.c = c;
		row.typed = 1'b0;
		row.r = '0;
		plan = {plan, row};
	endfunction

	function automatic void add_typed(corner_t c, result_t r);
		row_t row;
		row.c = c;
		row.typed = 1'b1;
		row.r = r;
		plan = {plan, row};
	endfunction

	function automatic logic [31:0] rnd_val(int mode);
		case (mode)
			0: return $urandom();
			1: return $urandom_range(0, 8 * ONE) - 4 * ONE;
			default: return $urandom_range(0, 255) - 128;
		endcase
	endfunction

	task automatic send(corner_t c, bit typed, result_t r);
		result_t want;
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < 33) begin
			corner_valid <= 1'b0;
			@(negedge clk);
		end
		corner_valid <= 1'b1;
		corner <= c;
		do @(posedge clk); while (corner_stall);
		if (tangent_step(c, want))
			tangent_q = {tangent_q, (typed ? r : want)};
	endtask

	task automatic check32(string name, logic [31:0] exp_v, logic [31:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s: expected %h, got %h", name, exp_v, got_v);
			errors++;
		end
	endtask

	// result checker
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && result_valid && !result_stall) begin
			if (tangent_q.size() == 0) begin
				$error("unexpected result %p", result);
				errors++;
			end else begin
				exp_r = tangent_q.pop_front();
				check32("tangent_x", exp_r.tangent_x, result.tangent_x);
				check32("tangent_y", exp_r.tangent_y, result.tangent_y);
				check32("tangent_z", exp_r.tangent_z, result.tangent_z);
				check32("bitangent_x", exp_r.bitangent_x, result.bitangent_x);
				check32("bitangent_y", exp_r.bitangent_y, result.bitangent_y);
				check32("bitangent_z", exp_r.bitangent_z, result.bitangent_z);
				if (exp_r.degenerate !== result.degenerate) begin
					$error("degenerate: expected %b, got %b", exp_r.degenerate,
						result.degenerate);
					errors++;
				end
			end
		end
	end

	// receiver, with one long hold-off
	initial begin
		int n;
		n = 0;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			n++;
			if (n >= HOLD_START && n < HOLD_START + HOLD_CYCLES)
				result_stall <= 1'b1;
			else if (calm)
				result_stall <= 1'b0;
			else
				result_stall <= ($urandom_range(0, 99) < 33);
		end
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		result_t r;
		corner_t c;
		int kind;
		int mode;
		int n;
		logic [31:0] u0, v0;
		errors = 0;
		calm = 1'b0;
		corner_cnt = 2'd0;
		c0_pos = '{default: '0};
		c1_pos = '{default: '0};
		c0_uv = '{default: '0};
		c1_uv = '{default: '0};
		corner_valid = 1'b0;
		corner = '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// all-zero triangle is degenerate
		r = '0;
		r.degenerate = 1'b1;
		add(mk(1, 0, 0, 0, 0, 0));
		add(mk(0, 0, 0, 0, 0, 0));
		add_typed(mk(0, 0, 0, 0, 0, 0), r);
		// unit triangle
		r = '0;
		r.tangent_x = ONE;
		r.bitangent_y = ONE;
		add(mk(1, 0, 0, 0, 0, 0));
		add(mk(0, ONE, 0, 0, ONE, 0));
		add_typed(mk(0, 0, ONE, 0, 0, ONE), r);
		// extremes, saturating both ways
		add(mk(1, MINV, MAXV, MINV, 0, 0));
		add(mk(0, MAXV, MINV, 0, 1, 0));
		add(mk(0, MINV, MAXV, MAXV, 0, 1));
		add(mk(1, MAXV, MAXV, MAXV, MAXV, MINV));
		add(mk(0, MINV, MINV, MINV, MINV, MAXV));
		add(mk(0, 32'hffffffff, 32'hffffffff, 32'hffffffff, MAXV, MAXV));
		// face start in mid triangle restarts it
		add(mk(1, 5, 6, 7, 3, 4));
		add(mk(0, ONE, 2, 3, ONE, 9));
		add(mk(1, 0, 0, 0, 0, 0));
		add(mk(0, 3 * ONE, ONE, 0, 2 * ONE, ONE));
		add(mk(0, ONE, 4 * ONE, ONE, ONE, 3 * ONE));
		// six corners in one face wrap into two triangles
		add(mk(1, 0, 0, 0, 0, 0));
		add(mk(0, ONE, 0, ONE, ONE, 0));
		add(mk(0, 0, ONE, 0, 0, ONE));
		add(mk(0, ONE, ONE, ONE, ONE, ONE));
		add(mk(0, 2 * ONE, ONE, 0, 3 * ONE, ONE));
		// collinear uv, degenerate
		r = '0;
		r.degenerate = 1'b1;
		add_typed(mk(0, 7, 8, 9, 5 * ONE, ONE), r);
		foreach (plan[i])
			send(plan[i].c, plan[i].typed, plan[i].r);

		n = 0;
		while (n < RANDOM_CORNERS) begin
			calm = (n >= 300 && n < 420);
			kind = $urandom_range(0, 9);
			mode = $urandom_range(0, 2);
			r = '0;
			if (kind == 9) begin
				c = mk($urandom_range(0, 1), $urandom(), $urandom(), $urandom(),
					$urandom(), $urandom());
				send(c, 1'b0, r);
				n++;
			end else begin
				u0 = rnd_val(mode);
				v0 = rnd_val(mode);
				for (int k = 0; k < 3; k++) begin
					c = mk(k == 0 ? 1'b1 : 1'b0, rnd_val(mode), rnd_val(mode),
						rnd_val(mode), rnd_val(mode), rnd_val(mode));
					if (k == 0) begin
						c.tex_u = u0;
						c.tex_v = v0;
					end else if (k == 2 && kind == 8) begin
						c.tex_u = u0;
						c.tex_v = v0;
					end
					if (k == 0 && kind == 7)
						c.face_start = 1'b0;
					send(c, 1'b0, r);
					n++;
				end
			end
		end
		calm = 1'b0;
		@(negedge clk);
		corner_valid <= 1'b0;

		while (tangent_q.size() > 0)
			@(posedge clk);
		repeat (700) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
